@@ rtl/joystick_differential_drive_mixer_unit_defines.svh @@
// Assertion macros for the joystick mixer
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define JDDM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JDDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JDDM_ASSERT(lbl, clk, rst, prop, msg)
`define JDDM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/jddm_pkg.sv @@
`default_nettype none
package jddm_pkg;

   localparam int XW = 27;
   localparam int ZW = 34;
   localparam int QW = 24;
   localparam int AW = 17;
   localparam int DIV_BITS = 16;
   localparam int TAB_LEN = 24;

   localparam logic [31:0] INV_GAIN = 32'd2608131496;
   localparam logic [31:0] PI_UNITS = 32'h8000_0000;

   localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef enum logic [1:0] {
      REG_FULL_SCALE = 2'd0,
      REG_MAX_DRIVE  = 2'd1,
      REG_DUTY_TOP   = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                 valid;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_stage_type;

   typedef struct packed {
      logic                valid;
      logic                sat;
      logic [QW-1:0]       r;
      logic [DIV_BITS-1:0] qt;
      logic [AW-1:0]       a;
   } div_stage_type;

   typedef struct packed {
      logic               valid;
      logic signed [10:0] left;
      logic signed [10:0] right;
   } drive_type;

endpackage
`default_nettype wire

@@ rtl/joystick_differential_drive_mixer_unit.sv @@
// channel | dir | ports             | contents
// req     | in  | req_t*            | stick_x, stick_y
// rsp     | out | rsp_t*            | drives, duties, reverse flags
// csr     | in  | csr_we/index/wdata| full_scale, max_drive, duty_top
// One request per cycle while the output register is empty or taken; each goes
// through CORDIC cells, gain multiply, 16 divider cells, two mixer stages, output.
// Synchronous reset clears the valid bits and loads register defaults.
// The whole pipeline advances when the output register is empty or taken.
`default_nettype none
`include "joystick_differential_drive_mixer_unit_defines.svh"
module joystick_differential_drive_mixer_unit #(
   parameter int DUTY_BITS = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // stick_x[7:0], stick_y[15:8]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // left_drive, right_drive, left_duty,
                                    // left_reverse, right_duty, right_reverse, pad
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [9:0]  csr_wdata
);
   localparam int DUTY_MAX = (DUTY_BITS >= 10) ? 1023 : (1 << DUTY_BITS) - 1;
   localparam logic [9:0] DUTY_LIM = DUTY_MAX[9:0];

   typedef struct packed {
      logic                     valid;
      logic [jddm_pkg::QW-1:0]  q;
      logic [jddm_pkg::AW-1:0]  a;
   } gain_type;

   logic [6:0] full_scale_ff;
   logic [9:0] max_drive_ff, duty_top_ff;
   logic       en;

   jddm_pkg::cordic_stage_type cs [CORDIC_STEPS+1];
   jddm_pkg::div_stage_type    ds [jddm_pkg::DIV_BITS+1];
   jddm_pkg::drive_type        drv;
   gain_type gn_ff, gn_in;

   logic signed [8:0]  xn, yn;
   logic [6:0]         fs;
   logic [55:0]        prod;
   logic [jddm_pkg::ZW-1:0] zs;
   logic [jddm_pkg::AW-1:0] m;

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [9:0]  lduty, rduty;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= 7'd100;
         max_drive_ff <= 10'd1000;
         duty_top_ff <= 10'd1023;
      end else if (csr_we) begin
         unique case (jddm_pkg::reg_index_type'(csr_index))
            jddm_pkg::REG_FULL_SCALE: full_scale_ff <= csr_wdata[6:0];
            jddm_pkg::REG_MAX_DRIVE:  max_drive_ff <= csr_wdata;
            jddm_pkg::REG_DUTY_TOP:   duty_top_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      xn = -$signed({req_tdata[7], req_tdata[7:0]});
      yn = $signed({req_tdata[15], req_tdata[15:8]});
      cs[0].valid = req_tvalid;
      if (xn < 0) begin
         cs[0].x = $signed({-xn, 16'h0});
         cs[0].y = $signed({-yn, 16'h0});
         cs[0].z = yn[8] ? -$signed({2'b00, jddm_pkg::PI_UNITS})
                         : $signed({2'b00, jddm_pkg::PI_UNITS});
      end else begin
         cs[0].x = $signed({xn, 16'h0});
         cs[0].y = $signed({yn, 16'h0});
         cs[0].z = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      jddm_cordic_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .en(en), .st_i(cs[i]), .st_o(cs[i+1])
      );
   end

   always_comb begin
      prod = (cs[CORDIC_STEPS].x < 0) ? 56'd0
           : 56'(cs[CORDIC_STEPS].x[25:0]) * jddm_pkg::INV_GAIN;
      zs = cs[CORDIC_STEPS].z + jddm_pkg::ZW'(jddm_pkg::PI_UNITS) + jddm_pkg::ZW'(16384);
      gn_in.valid = cs[CORDIC_STEPS].valid;
      gn_in.q = prod[55:32];
      gn_in.a = zs[31:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gn_ff.valid <= 1'b0;
      end else if (en) begin
         gn_ff <= gn_in;
      end
   end

   always_comb begin
      fs = (full_scale_ff == 7'd0) ? 7'd1 : full_scale_ff;
      ds[0].valid = gn_ff.valid;
      ds[0].sat = gn_ff.q >= {1'b0, fs, 16'h0};
      ds[0].r = gn_ff.q;
      ds[0].qt = '0;
      ds[0].a = gn_ff.a;
   end

   for (genvar k = 0; k < jddm_pkg::DIV_BITS; k++) begin : g_div
      jddm_div_cell #(.BIT(jddm_pkg::DIV_BITS-1-k)) u_cell (
         .clock(clock), .reset(reset), .en(en), .divisor(fs),
         .st_i(ds[k]), .st_o(ds[k+1])
      );
   end

   assign m = ds[jddm_pkg::DIV_BITS].sat ? 17'h10000
            : {1'b0, ds[jddm_pkg::DIV_BITS].qt};

   jddm_mix u_mix (
      .clock(clock), .reset(reset), .en(en), .max_drive(max_drive_ff),
      .m_valid(ds[jddm_pkg::DIV_BITS].valid), .m(m),
      .a(ds[jddm_pkg::DIV_BITS].a), .drv_o(drv)
   );

   function automatic logic [9:0] duty(input logic signed [10:0] d,
                                       input logic [9:0] top);
      logic signed [11:0] v;
      if (d[10]) begin
         v = $signed({2'b00, top}) + $signed({d[10], d});
         if (v[11]) v = '0;
      end else begin
         v = $signed({d[10], d});
      end
      return (v[10:0] > {1'b0, DUTY_LIM}) ? DUTY_LIM : v[9:0];
   endfunction

   always_comb begin
      lduty = duty(drv.left, duty_top_ff);
      rduty = duty(drv.right, duty_top_ff);
      rsp_data_in = {4'h0, drv.right[10], rduty, drv.left[10], lduty,
                     drv.right, drv.left};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= drv.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `JDDM_ASSERT(a_rev_sign, clock, reset, rsp_tvalid |-> (rsp_tdata[32] == rsp_tdata[10]), "left reverse flag mismatch")
   `JDDM_ASSERT(a_zero_drive, clock, reset, (rsp_tvalid && rsp_tdata[10:0] == 11'd0) |-> (rsp_tdata[31:22] == 10'd0), "zero drive with nonzero duty")
   `JDDM_ASSERT(a_drive_clamp, clock, reset, (rsp_tvalid && !rsp_tdata[21]) |-> (rsp_tdata[20:11] <= max_drive_ff), "right drive above max")
endmodule
`default_nettype wire

@@ rtl/jddm_cordic_cell.sv @@
`default_nettype none
module jddm_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           en,
   input  jddm_pkg::cordic_stage_type    st_i,
   output jddm_pkg::cordic_stage_type    st_o
);
   jddm_pkg::cordic_stage_type st_ff, st_in;
   logic signed [jddm_pkg::XW-1:0] xs, ys;
   logic signed [jddm_pkg::ZW-1:0] ang;

   always_comb begin
      xs = st_i.x >>> STEP;
      ys = st_i.y >>> STEP;
      ang = $signed({2'b00, jddm_pkg::ATAN_TAB[STEP]});
      st_in = st_i;
      if (st_i.y < 0) begin
         st_in.x = st_i.x - ys;
         st_in.y = st_i.y + xs;
         st_in.z = st_i.z - ang;
      end else begin
         st_in.x = st_i.x + ys;
         st_in.y = st_i.y - xs;
         st_in.z = st_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;
endmodule
`default_nettype wire

@@ rtl/jddm_div_cell.sv @@
`default_nettype none
module jddm_div_cell #(
   parameter int BIT = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        en,
   input  wire  [6:0]                 divisor,
   input  jddm_pkg::div_stage_type    st_i,
   output jddm_pkg::div_stage_type    st_o
);
   jddm_pkg::div_stage_type st_ff, st_in;
   logic [jddm_pkg::QW-1:0] dv;

   always_comb begin
      dv = jddm_pkg::QW'(divisor) << BIT;
      st_in = st_i;
      if (!st_i.sat && st_i.r >= dv) begin
         st_in.r = st_i.r - dv;
         st_in.qt[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;
endmodule
`default_nettype wire

@@ rtl/jddm_mix.sv @@
`default_nettype none
module jddm_mix (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        en,
   input  wire  [9:0]                 max_drive,
   input  wire                        m_valid,
   input  wire  [jddm_pkg::AW-1:0]    m,
   input  wire  [jddm_pkg::AW-1:0]    a,
   output jddm_pkg::drive_type        drv_o
);
   typedef struct packed {
      logic               valid;
      logic signed [35:0] pl;
      logic signed [35:0] pr;
   } power_type;

   localparam logic signed [17:0] UNIT = 18'sd65536;

   power_type          pw_ff, pw_in;
   jddm_pkg::drive_type drv_ff, drv_in;
   logic signed [17:0] low4, fl, fr, ms;

   function automatic logic signed [10:0] scale(input logic signed [35:0] p,
                                                input logic [9:0] md);
      logic [35:0] mag;
      logic [42:0] prod;
      logic [10:0] dq;
      logic [9:0]  d;
      mag = p[35] ? 36'(-p) : 36'(p);
      prod = mag[32:0] * md;
      dq = prod[42:32];
      d = (dq > {1'b0, md}) ? md : dq[9:0];
      return p[35] ? -$signed({1'b0, d}) : $signed({1'b0, d});
   endfunction

   always_comb begin
      low4 = $signed({1'b0, a[14:0], 2'b00});
      ms = $signed({1'b0, m});
      case (a[16:15])
         2'd0: begin fl = UNIT;        fr = low4 - UNIT; end
         2'd1: begin fl = UNIT - low4; fr = UNIT;        end
         2'd2: begin fl = -UNIT;       fr = UNIT - low4; end
         default: begin fl = low4 - UNIT; fr = -UNIT;    end
      endcase
      pw_in.valid = m_valid;
      pw_in.pl = ms * fl;
      pw_in.pr = ms * fr;
      drv_in.valid = pw_ff.valid;
      drv_in.left = scale(pw_ff.pl, max_drive);
      drv_in.right = scale(pw_ff.pr, max_drive);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff.valid <= 1'b0;
         drv_ff.valid <= 1'b0;
      end else if (en) begin
         pw_ff <= pw_in;
         drv_ff <= drv_in;
      end
   end

   assign drv_o = drv_ff;
endmodule
`default_nettype wire
